/* rtl/lphs_pkg.sv */
// Package for the linear probing hash set core: shared constants, codes and
// the command and status structs between the controller and the datapath.
// Depends on nothing.
`default_nettype none

package lphs_pkg;

  localparam int unsigned DEPTH_DEFAULT = 256;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned CAP_REG_W = 9;
  localparam int unsigned MIN_CAPACITY = 16;
  localparam logic [CAP_REG_W-1:0] CAP_RESET = 9'd16;
  localparam logic [KEY_W-1:0] HASH_MUL = 32'd2654435761;
  localparam int unsigned REM_STEP_BITS = 4;
  localparam int unsigned REM_STEPS = KEY_W / REM_STEP_BITS;
  localparam int unsigned COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_FAILED = 2'd3;

  typedef struct packed {
    logic       load;
    logic       clear_set;
    logic       sweep_init;
    logic       sweep_step;
    logic       hash;
    logic       mod_step;
    logic       probe_start;
    logic       advance;
    logic       store;
    logic       mark_failed;
    logic       finish;
    logic       found;
    logic [1:0] status;
  } lphs_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic mod_last;
    logic used;
    logic key_match;
    logic probe_last;
    logic is_insert;
    logic set_failed;
    logic count_zero;
  } lphs_stat_t;

endpackage

`default_nettype wire

/* rtl/lphs_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module lphs_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/lphs_ctrl.sv */
// Controller state machine of the hash set core: sequences clearing sweeps,
// hashing, the modulo steps and slot probing. Depends on lphs_pkg.
`default_nettype none

module lphs_ctrl
  import lphs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] action,
  input  wire lphs_stat_t stat,
  output logic            busy,
  output lphs_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SWEEP_RST = 3'd1;
  localparam logic [2:0] S_SWEEP_CLR = 3'd2;
  localparam logic [2:0] S_HASH = 3'd3;
  localparam logic [2:0] S_MOD = 3'd4;
  localparam logic [2:0] S_PSTART = 3'd5;
  localparam logic [2:0] S_PROBE = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP_RST;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r) inside
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (action)
            ACT_CLEAR: begin
              cmd.clear_set = 1'b1;
              cmd.sweep_init = 1'b1;
              state_nxt = S_SWEEP_CLR;
            end
            ACT_INSERT: begin
              if (stat.set_failed) begin
                cmd.finish = 1'b1;
                cmd.status = ST_FAILED;
              end else begin
                state_nxt = S_HASH;
              end
            end
            ACT_LOOKUP: begin
              if (stat.set_failed) begin
                cmd.finish = 1'b1;
                cmd.status = ST_FAILED;
              end else if (stat.count_zero) begin
                cmd.finish = 1'b1;
                cmd.status = ST_OK;
              end else begin
                state_nxt = S_HASH;
              end
            end
            default: begin
              cmd.finish = 1'b1;
              cmd.status = ST_OK;
            end
          endcase
        end
      end
      S_SWEEP_RST, S_SWEEP_CLR: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
          if (state_r == S_SWEEP_CLR) begin
            cmd.finish = 1'b1;
            cmd.status = ST_OK;
          end
        end
      end
      S_HASH: begin
        cmd.hash = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_nxt = S_PSTART;
        end
      end
      S_PSTART: begin
        cmd.probe_start = 1'b1;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (!stat.used) begin
          cmd.finish = 1'b1;
          cmd.status = ST_OK;
          cmd.store = stat.is_insert;
          state_nxt = S_IDLE;
        end else if (stat.key_match) begin
          cmd.finish = 1'b1;
          if (stat.is_insert) begin
            cmd.mark_failed = 1'b1;
            cmd.status = ST_DUP;
          end else begin
            cmd.found = 1'b1;
            cmd.status = ST_OK;
          end
          state_nxt = S_IDLE;
        end else if (stat.probe_last) begin
          cmd.finish = 1'b1;
          cmd.status = stat.is_insert ? ST_FULL : ST_OK;
          state_nxt = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/lphs_dp.sv */
// Datapath of the hash set core: capacity register, hash multiplier, modulo
// unit, probe pointer, slot table RAM and result registers.
// Depends on lphs_pkg and lphs_ram.
`default_nettype none

module lphs_dp
  import lphs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lphs_cmd_t            cmd,
  output lphs_stat_t                stat,
  input  wire logic [1:0]           in_action,
  input  wire logic [KEY_W-1:0]     in_key,
  input  wire logic                 cfg_valid,
  input  wire logic [CAP_REG_W-1:0] cfg_data,
  output logic                      out_valid,
  output logic                      out_found,
  output logic [1:0]                out_status
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CAP_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = (CAP_W > CAP_REG_W) ? CAP_W : CAP_REG_W;
  localparam int unsigned MC_W = $clog2(REM_STEPS);
  localparam int unsigned ENTRY_W = KEY_W + 1;

  logic [CAP_REG_W-1:0] cap_cfg_r;
  logic [CAP_W-1:0]     cap_r;
  logic [KEY_W-1:0]     key_r;
  logic [1:0]           action_r;
  logic [KEY_W-1:0]     mul_r;
  logic [CAP_W-1:0]     rem_r;
  logic [MC_W-1:0]      mod_cnt_r;
  logic [IDX_W-1:0]     slot_r;
  logic [CAP_W-1:0]     probe_cnt_r;
  logic [IDX_W-1:0]     sweep_idx_r;
  logic [COUNT_W-1:0]   count_r;
  logic                 failed_r;
  logic                 out_valid_r;
  logic                 out_found_r;
  logic [1:0]           out_status_r;

  logic [CW-1:0]        cap_ext;
  logic [CW-1:0]        cap_sel;
  logic [CAP_W-1:0]     rem_nxt;
  logic [CAP_W:0]       slot_inc;
  logic [IDX_W-1:0]     slot_next;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_cfg_r <= CAP_RESET;
    end else if (cfg_valid) begin
      cap_cfg_r <= cfg_data;
    end
  end

  assign cap_ext = CW'(cap_cfg_r);

  always_comb begin
    if (cap_ext < CW'(MIN_CAPACITY)) begin
      cap_sel = CW'(MIN_CAPACITY);
    end else if (cap_ext > CW'(TABLE_DEPTH)) begin
      cap_sel = CW'(TABLE_DEPTH);
    end else begin
      cap_sel = cap_ext;
    end
  end

  always_comb begin
    logic [CAP_W:0] r;
    r = {1'b0, rem_r};
    for (int i = 0; i < REM_STEP_BITS; i++) begin
      r = {r[CAP_W-1:0], mul_r[KEY_W-1-i]};
      if (r >= {1'b0, cap_r}) begin
        r = r - {1'b0, cap_r};
      end
    end
    rem_nxt = r[CAP_W-1:0];
  end

  assign slot_inc = (CAP_W + 1)'(slot_r) + 1'b1;
  assign slot_next = (slot_inc >= {1'b0, cap_r}) ? '0 : slot_inc[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key;
      action_r <= in_action;
      cap_r <= cap_sel[CAP_W-1:0];
    end
    if (cmd.hash) begin
      mul_r <= key_r * HASH_MUL;
      rem_r <= '0;
    end else if (cmd.mod_step) begin
      mul_r <= mul_r << REM_STEP_BITS;
      rem_r <= rem_nxt;
    end
    if (cmd.probe_start) begin
      slot_r <= rem_r[IDX_W-1:0];
      probe_cnt_r <= CAP_W'(1);
    end else if (cmd.advance) begin
      slot_r <= slot_next;
      probe_cnt_r <= probe_cnt_r + 1'b1;
    end
    out_found_r <= cmd.found;
    out_status_r <= cmd.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_cnt_r <= '0;
      sweep_idx_r <= '0;
      count_r <= '0;
      failed_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.hash) begin
        mod_cnt_r <= '0;
      end else if (cmd.mod_step) begin
        mod_cnt_r <= mod_cnt_r + 1'b1;
      end
      if (cmd.sweep_init) begin
        sweep_idx_r <= '0;
      end else if (cmd.sweep_step) begin
        sweep_idx_r <= sweep_idx_r + 1'b1;
      end
      if (cmd.clear_set) begin
        count_r <= '0;
        failed_r <= 1'b0;
      end else begin
        if (cmd.store && (count_r != COUNT_MAX)) begin
          count_r <= count_r + 1'b1;
        end
        if (cmd.mark_failed) begin
          failed_r <= 1'b1;
        end
      end
      out_valid_r <= cmd.finish;
    end
  end

  always_comb begin
    if (cmd.sweep_step) begin
      ram_we = 1'b1;
      ram_waddr = sweep_idx_r;
      ram_wdata = '0;
    end else begin
      ram_we = cmd.store;
      ram_waddr = slot_r;
      ram_wdata = {1'b1, key_r};
    end
  end

  always_comb begin
    if (cmd.probe_start) begin
      ram_raddr = rem_r[IDX_W-1:0];
    end else if (cmd.advance) begin
      ram_raddr = slot_next;
    end else begin
      ram_raddr = slot_r;
    end
  end

  lphs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign stat.sweep_last = (sweep_idx_r == IDX_W'(TABLE_DEPTH - 1));
  assign stat.mod_last = (mod_cnt_r == MC_W'(REM_STEPS - 1));
  assign stat.used = ram_rdata[KEY_W];
  assign stat.key_match = (ram_rdata[KEY_W-1:0] == key_r);
  assign stat.probe_last = (probe_cnt_r == cap_r);
  assign stat.is_insert = (action_r == ACT_INSERT);
  assign stat.set_failed = failed_r;
  assign stat.count_zero = (count_r == '0);

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

/* rtl/linear_probe_hash_set_core.sv */
// Top level of the linear probing hash set core: joins the controller and
// the datapath. Depends on lphs_pkg, lphs_ctrl, lphs_dp and lphs_ram.
//
//   Channel   Ports                                  Transfer
//   input     start, busy, in_action, in_key         start high while busy low
//   result    out_valid, out_found, out_status       one-cycle strobe, no stall
//   config    cfg_valid, cfg_ready, cfg_table_capacity  valid and ready high
//
// After reset the core sweeps all TABLE_DEPTH slots, one per cycle, and stays
// busy meanwhile. A clear word also sweeps all TABLE_DEPTH slots. Insert and lookup
// pass through the hash state, REM_STEPS modulo steps and the probe setup state, then
// probe slots in order; the result follows the final probe in the next cycle. Words
// answered without probing or sweeping return their result the next cycle.
// The result is held for exactly one cycle; the receiver cannot stall it.
`default_nettype none

module linear_probe_hash_set_core
  import lphs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_action,
  input  wire logic signed [31:0]   in_key,
  output logic                      out_valid,
  output logic                      out_found,
  output logic [1:0]                out_status,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CAP_REG_W-1:0] cfg_table_capacity
);

  lphs_cmd_t  cmd;
  lphs_stat_t stat;

  assign cfg_ready = 1'b1;

  lphs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .action(in_action),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  lphs_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_action (in_action),
    .in_key    ($unsigned(in_key)),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_table_capacity),
    .out_valid (out_valid),
    .out_found (out_found),
    .out_status(out_status)
  );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for linear_probe_hash_set_core. It drives command words and
// capacity writes, and a scoreboard class predicts found and status for every accepted word.
// Depends on lphs_pkg and the core's RTL.
module testbench;
  import lphs_pkg::*;

  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned ITEM_TARGET = 400;
  localparam int unsigned CALM_FROM = 340;
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef struct packed {
    logic       found;
    logic [1:0] status;
  } set_answer_t;

  class hash_set_scoreboard;
    logic [KEY_W-1:0] slot_key [DEPTH_DEFAULT];
    bit slot_used [DEPTH_DEFAULT];
    int unsigned stored;
    bit failed;
    logic [CAP_REG_W-1:0] capacity;
    set_answer_t answers_due [$];
    int unsigned errors;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_key[i] = '0;
      end
      stored = 0;
      failed = 1'b0;
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_REG_W-1:0] value);
      capacity = value;
    endfunction

    function int unsigned slots_for(logic [CAP_REG_W-1:0] value);
      if (value < MIN_CAPACITY) return MIN_CAPACITY;
      if (value > DEPTH_DEFAULT) return DEPTH_DEFAULT;
      return 32'(value);
    endfunction

    function int unsigned home_of(logic [KEY_W-1:0] key, int unsigned slots);
      logic [KEY_W-1:0] product;
      product = key * HASH_MUL;
      return product % slots;
    endfunction

    function int unsigned pending();
      return answers_due.size();
    endfunction

    function void note_word(logic [1:0] act, logic [KEY_W-1:0] key);
      int unsigned slots;
      int unsigned s;
      int unsigned n;
      set_answer_t answer;
      slots = slots_for(capacity);
      answer.found = 1'b0;
      answer.status = ST_OK;
      case (act)
        ACT_CLEAR: begin
          foreach (slot_used[i]) slot_used[i] = 1'b0;
          stored = 0;
          failed = 1'b0;
        end
        ACT_INSERT: begin
          if (failed) begin
            answer.status = ST_FAILED;
          end else begin
            answer.status = ST_FULL;
            s = home_of(key, slots);
            for (n = 0; n < slots; n++) begin
              if (!slot_used[s]) begin
                slot_used[s] = 1'b1;
                slot_key[s] = key;
                if (stored < COUNT_MAX) stored++;
                answer.status = ST_OK;
                break;
              end
              if (slot_key[s] == key) begin
                failed = 1'b1;
                answer.status = ST_DUP;
                break;
              end
              s = (s + 1 >= slots) ? 0 : s + 1;
            end
          end
        end
        ACT_LOOKUP: begin
          if (failed) begin
            answer.status = ST_FAILED;
          end else if (stored != 0) begin
            s = home_of(key, slots);
            for (n = 0; n < slots && slot_used[s]; n++) begin
              if (slot_key[s] == key) begin
                answer.found = 1'b1;
                break;
              end
              s = (s + 1 >= slots) ? 0 : s + 1;
            end
          end
        end
        default: ;
      endcase
      answers_due.push_back(answer);
    endfunction

    function void check_result(logic found, logic [1:0] status);
      set_answer_t want;
      if (answers_due.size() == 0) begin
        $error("unexpected result: found %0d status %0d", found, status);
        errors++;
        return;
      end
      want = answers_due.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, found);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [1:0] in_action = ACT_CLEAR;
  logic [KEY_W-1:0] in_key = '0;
  logic cfg_valid = 1'b0;
  logic [CAP_REG_W-1:0] cfg_table_capacity = CAP_RESET;
  logic busy;
  logic out_valid;
  logic out_found;
  logic [1:0] out_status;
  logic cfg_ready;

  hash_set_scoreboard tracker = new();
  int unsigned quiet_cycles = 0;
  int unsigned words_sent = 0;
  bit sender_idles = 1'b1;

  linear_probe_hash_set_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_key(in_key),
    .out_valid(out_valid),
    .out_found(out_found),
    .out_status(out_status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_table_capacity(cfg_table_capacity)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) tracker.check_result(out_found, out_status);
    if (rst_n && start && busy === 1'b0) tracker.note_word(in_action, in_key);
    if (rst_n && cfg_valid && cfg_ready === 1'b1) tracker.set_capacity(cfg_table_capacity);
    if (rst_n && ((start && busy === 1'b0) || out_valid === 1'b1 ||
        (cfg_valid && cfg_ready === 1'b1))) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("linear_probe_hash_set_core test failed");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] act, input logic [KEY_W-1:0] key);
    start <= 1'b1;
    in_action <= act;
    in_key <= key;
    do @(posedge clk); while (busy !== 1'b0);
    words_sent++;
    if (sender_idles && words_sent < CALM_FROM && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic settle_block;
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0 || busy !== 1'b0);
  endtask

  task automatic write_capacity(input logic [CAP_REG_W-1:0] value);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_table_capacity <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  // With the reset capacity of 16, sixteen distinct keys fill the table completely.
  task automatic run_directed;
    logic [KEY_W-1:0] fill_keys [16] = '{
      32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'h0000_0010, 32'h0000_0100, 32'h1234_5678,
      32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h5555_5555, 32'hAAAA_AAAA,
      32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0011, 32'h0000_0021};
    send_word(ACT_LOOKUP, 32'h0000_0000);
    send_word(ACT_IGNORED, 32'hFFFF_FFFF);
    foreach (fill_keys[i]) send_word(ACT_INSERT, fill_keys[i]);
    send_word(ACT_INSERT, 32'h0BAD_0000);
    send_word(ACT_LOOKUP, 32'h0BAD_0000);
    send_word(ACT_LOOKUP, 32'h8000_0000);
    send_word(ACT_INSERT, 32'h7FFF_FFFF);
    send_word(ACT_LOOKUP, 32'h8000_0000);
    send_word(ACT_INSERT, 32'h0BAD_0001);
    send_word(ACT_CLEAR, 32'hFFFF_FFFF);
    send_word(ACT_LOOKUP, 32'hFFFF_FFFF);
  endtask

  task automatic run_random_phase;
    logic [KEY_W-1:0] held [$];
    logic [KEY_W-1:0] key;
    logic [CAP_REG_W-1:0] cap_value;
    int unsigned slots;
    int unsigned steps;
    int unsigned pick;
    bit fill_mode;
    case ($urandom_range(0, 9))
      0: cap_value = '0;
      1: cap_value = '1;
      2: cap_value = 9'd256;
      3: cap_value = 9'd16;
      4: cap_value = 9'($urandom_range(257, 511));
      5: cap_value = 9'($urandom_range(0, 15));
      default: cap_value = 9'($urandom_range(17, 64));
    endcase
    write_capacity(cap_value);
    slots = tracker.slots_for(cap_value);
    sender_idles = ($urandom_range(0, 3) != 0);
    fill_mode = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 4) != 0) send_word(ACT_CLEAR, $urandom());
    steps = $urandom_range(4, (slots < 32) ? slots + 8 : 40);
    repeat (steps) begin
      pick = $urandom_range(0, 99);
      key = $urandom();
      if (pick < 55 || held.size() == 0 || (fill_mode && pick < 90)) begin
        send_word(ACT_INSERT, key);
        held.push_back(key);
      end else if (pick < 80) begin
        send_word(ACT_LOOKUP, held[$urandom_range(0, held.size() - 1)]);
      end else if (pick < 91) begin
        send_word(ACT_LOOKUP, key);
      end else if (pick < 93) begin
        send_word(ACT_INSERT, held[$urandom_range(0, held.size() - 1)]);
      end else if (pick < 96) begin
        send_word(ACT_IGNORED, key);
      end else begin
        send_word(2'($urandom_range(0, 3)), key);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    while (words_sent < ITEM_TARGET) run_random_phase();
    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("linear_probe_hash_set_core test passed");
    end else begin
      $display("linear_probe_hash_set_core test failed");
    end
    $finish;
  end
endmodule
